/* hdl/i2cms_pkg.sv */
// Shared types and constants for the I2C master transfer sequencer.
// No dependencies; imported by i2cms_step, the top level and the testbench.
package i2cms_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 128;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_EVENT = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    ST_BUS_ERROR   = 5'd0,
    ST_START       = 5'd1,
    ST_REP_START   = 5'd2,
    ST_TX_ADR_ACK  = 5'd3,
    ST_TX_ADR_NACK = 5'd4,
    ST_TX_DAT_ACK  = 5'd5,
    ST_TX_DAT_NACK = 5'd6,
    ST_ARB_LOST    = 5'd7,
    ST_RX_ADR_ACK  = 5'd8,
    ST_RX_ADR_NACK = 5'd9,
    ST_RX_DAT_ACK  = 5'd10,
    ST_RX_DAT_NACK = 5'd11
  } status_t;

  // Decision for one item, carried alongside the buffer read.
  typedef struct packed {
    logic       control_valid;
    logic       bus_enable;
    logic       event_enable;
    logic       send_start;
    logic       send_stop;
    logic       send_ack;
    logic       tx_valid;
    logic       read_sel;
    logic       transfer_ok;
    logic       fault_valid;
    logic [4:0] fault_status;
  } result_t;

endpackage

/* hdl/i2cms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/i2cms_step.sv */
// Step rule and sequencer state (pointer, length, done flag, last fault).
// Depends on i2cms_pkg; drives the buffer RAM ports and the per-item decision.
module i2cms_step #(
  parameter int BUFFER_DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      opcode,
  input  logic [6:0]                      index,
  input  logic [7:0]                      data,
  input  logic [7:0]                      length,
  input  logic [4:0]                      status,
  output logic                            wr_req,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output logic [7:0]                      wr_data,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output i2cms_pkg::result_t              res
);
  import i2cms_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

  logic [7:0] byte_pointer, byte_pointer_next;
  logic [7:0] transfer_length, transfer_length_next;
  logic       done_ok, done_ok_next;
  logic [4:0] last_fault, last_fault_next;

  logic [7:0] index_w;
  logic       index_ok;
  logic       pointer_ok;
  logic       rewind;
  logic [7:0] ptr_base;
  logic [7:0] ptr_inc;
  logic [7:0] rx_ptr;
  logic       rx_ack;

  assign index_w    = {1'b0, index};
  assign index_ok   = {1'b0, index_w} < DEPTH_W;
  assign pointer_ok = {1'b0, byte_pointer} < DEPTH_W;
  assign rewind     = (status == ST_START) || (status == ST_REP_START);
  assign ptr_base   = rewind ? 8'd0 : byte_pointer;
  assign ptr_inc    = byte_pointer + 8'd1;
  assign rx_ptr     = (status == ST_RX_DAT_ACK) ? ptr_inc : byte_pointer;
  assign rx_ack     = ({1'b0, rx_ptr} + 9'd1) < {1'b0, transfer_length};

  always_comb begin
    byte_pointer_next    = byte_pointer;
    transfer_length_next = transfer_length;
    done_ok_next         = done_ok;
    last_fault_next      = last_fault;
    wr_req               = 1'b0;
    wr_addr              = index_w[AW-1:0];
    wr_data              = data;
    rd_addr              = index_w[AW-1:0];
    res                  = '0;
    unique case (opcode_t'(opcode))
      OP_WRITE: begin
        wr_req = index_ok;
      end
      OP_START: begin
        transfer_length_next = ({1'b0, length} > DEPTH_W) ? DEPTH_W[7:0] : length;
        done_ok_next         = 1'b0;
        res.control_valid    = 1'b1;
        res.bus_enable       = 1'b1;
        res.event_enable     = 1'b1;
        res.send_start       = 1'b1;
      end
      OP_READ: begin
        res.read_sel = index_ok;
      end
      OP_EVENT: begin
        res.control_valid = 1'b1;
        res.bus_enable    = 1'b1;
        unique case (status)
          ST_START, ST_REP_START, ST_TX_ADR_ACK, ST_TX_DAT_ACK: begin
            rd_addr = ptr_base[AW-1:0];
            if (ptr_base < transfer_length) begin
              res.tx_valid      = 1'b1;
              res.event_enable  = 1'b1;
              byte_pointer_next = ptr_base + 8'd1;
            end else begin
              byte_pointer_next = ptr_base;
              done_ok_next      = 1'b1;
              res.send_stop     = 1'b1;
            end
          end
          ST_RX_ADR_ACK, ST_RX_DAT_ACK: begin
            if (status == ST_RX_DAT_ACK) begin
              wr_req  = pointer_ok;
              wr_addr = byte_pointer[AW-1:0];
            end
            byte_pointer_next = rx_ptr;
            res.event_enable  = 1'b1;
            res.send_ack      = rx_ack;
          end
          ST_RX_DAT_NACK: begin
            wr_req        = pointer_ok;
            wr_addr       = byte_pointer[AW-1:0];
            done_ok_next  = 1'b1;
            res.send_stop = 1'b1;
          end
          ST_ARB_LOST: begin
            res.event_enable = 1'b1;
            res.send_start   = 1'b1;
          end
          default: begin
            last_fault_next = status;
            res.fault_valid = 1'b1;
          end
        endcase
      end
    endcase
    res.transfer_ok  = done_ok_next;
    res.fault_status = last_fault_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pointer    <= '0;
      transfer_length <= '0;
      done_ok         <= 1'b0;
      last_fault      <= '0;
    end else if (accept) begin
      byte_pointer    <= byte_pointer_next;
      transfer_length <= transfer_length_next;
      done_ok         <= done_ok_next;
      last_fault      <= last_fault_next;
    end
  end

endmodule

/* hdl/i2c_master_transfer_sequencer.sv */
// I2C master transfer sequencer, top level: step rule, byte buffer RAM, output register.
// Depends on i2cms_pkg, i2cms_step and i2cms_ram.
//
// Takes one item per clock cycle while item_stall is low. The decision and the buffer
// access happen at the accepting edge, where the buffer RAM also registers its read data
// alongside the s1 stage; the result register loads from s1 and the read data when the
// pipeline next advances. The pipeline advances as a whole while the result register is
// empty or being taken, so item_stall is result_stall gated by result_valid.
// The 8-bit buffer is a single write port, single registered read port RAM of
// BUFFER_DEPTH entries with no reset and no clearing pass; reading an entry that was
// never written returns whatever the RAM holds.
module i2c_master_transfer_sequencer #(
  parameter int BUFFER_DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] opcode,
  input  logic [6:0] index,
  input  logic [7:0] data,
  input  logic [7:0] length,
  input  logic [4:0] status,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       control_valid,
  output logic       bus_enable,
  output logic       event_enable,
  output logic       send_start,
  output logic       send_stop,
  output logic       send_ack,
  output logic [7:0] tx_byte,
  output logic       tx_valid,
  output logic [7:0] read_byte,
  output logic       transfer_ok,
  output logic       fault_valid,
  output logic [4:0] fault_status
);
  import i2cms_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          advance;
  logic          accept;
  logic          wr_req;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  result_t       res;
  result_t       s1;
  logic          s1_valid;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;
  assign accept     = item_valid && advance;

  i2cms_step #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .opcode  (opcode),
    .index   (index),
    .data    (data),
    .length  (length),
    .status  (status),
    .wr_req  (wr_req),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .res     (res)
  );

  i2cms_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && wr_req),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= accept;
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1            <= res;
      control_valid <= s1.control_valid;
      bus_enable    <= s1.bus_enable;
      event_enable  <= s1.event_enable;
      send_start    <= s1.send_start;
      send_stop     <= s1.send_stop;
      send_ack      <= s1.send_ack;
      tx_valid      <= s1.tx_valid;
      tx_byte       <= s1.tx_valid ? rd_data : 8'd0;
      read_byte     <= s1.read_sel ? rd_data : 8'd0;
      transfer_ok   <= s1.transfer_ok;
      fault_valid   <= s1.fault_valid;
      fault_status  <= s1.fault_status;
    end
  end

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item did not reach the read stage");

  a_tx_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && tx_valid |-> control_valid && event_enable && !send_stop)
    else $error("tx byte issued without a proper control word");

  a_stop_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && send_stop |-> transfer_ok && !event_enable)
    else $error("stop issued without marking the transfer good");

  a_fault_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && fault_valid |-> control_valid && !event_enable && !tx_valid)
    else $error("fault captured with events still enabled");

  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && (read_byte != 8'd0) |-> !control_valid)
    else $error("buffer read returned with a control word");

endmodule

/* tb/i2c_master_transfer_sequencer_test.sv */
// Self-checking testbench for i2c_master_transfer_sequencer: directed table, then random
// write/read transfers, aborts, faults and noise checked against an in-bench predictor.
// Depends on i2cms_pkg and the sequencer RTL.
module i2c_master_transfer_sequencer_test;
  import i2cms_pkg::*;

  localparam int DEPTH = DEFAULT_BUFFER_DEPTH;
  localparam int ITEMS = 550;

  typedef struct packed {
    logic       control_valid;
    logic       bus_enable;
    logic       event_enable;
    logic       send_start;
    logic       send_stop;
    logic       send_ack;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_byte;
    logic       transfer_ok;
    logic       fault_valid;
    logic [4:0] fault_status;
  } ctl_word_t;

  typedef struct packed {
    opcode_t    op;
    logic [6:0] index;
    logic [7:0] data;
    logic [7:0] length;
    logic [4:0] status;
  } seq_item_t;

  typedef struct {
    int        op;
    int        index;
    int        data;
    int        length;
    int        status;
    bit        given;
    ctl_word_t want;
  } table_row_t;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  logic [1:0] opcode;
  logic [6:0] index;
  logic [7:0] data;
  logic [7:0] length;
  logic [4:0] status;
  logic       result_valid;
  logic       result_stall;
  logic       control_valid;
  logic       bus_enable;
  logic       event_enable;
  logic       send_start;
  logic       send_stop;
  logic       send_ack;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic [7:0] read_byte;
  logic       transfer_ok;
  logic       fault_valid;
  logic [4:0] fault_status;

  i2c_master_transfer_sequencer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .index        (index),
    .data         (data),
    .length       (length),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .control_valid(control_valid),
    .bus_enable   (bus_enable),
    .event_enable (event_enable),
    .send_start   (send_start),
    .send_stop    (send_stop),
    .send_ack     (send_ack),
    .tx_byte      (tx_byte),
    .tx_valid     (tx_valid),
    .read_byte    (read_byte),
    .transfer_ok  (transfer_ok),
    .fault_valid  (fault_valid),
    .fault_status (fault_status)
  );

  // predictor state
  logic [7:0] buf_mem [DEPTH];
  bit         buf_written [DEPTH];
  logic [7:0] byte_ptr;
  logic [7:0] xfer_len;
  logic       xfer_ok;
  logic [4:0] fault_code;

  ctl_word_t  pending_words [$];
  ctl_word_t  last_word;
  int         fail_count;
  int         items_sent;
  int         words_seen;
  int         idle_pct;
  int         stall_pct;
  bit         quiet;
  table_row_t dir_tab [26];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void store_byte(logic [7:0] at, logic [7:0] val);
    if (at < DEPTH) begin
      buf_mem[at[6:0]] = val;
      buf_written[at[6:0]] = 1'b1;
    end
  endfunction

  function automatic ctl_word_t step_sequencer(seq_item_t it);
    ctl_word_t r;
    r = '0;
    case (it.op)
      OP_WRITE: store_byte({1'b0, it.index}, it.data);
      OP_READ:  r.read_byte = buf_mem[it.index];
      OP_START: begin
        xfer_len = (it.length > DEPTH) ? 8'(DEPTH) : it.length;
        xfer_ok = 1'b0;
        r.control_valid = 1'b1;
        r.bus_enable = 1'b1;
        r.event_enable = 1'b1;
        r.send_start = 1'b1;
      end
      default: begin
        r.control_valid = 1'b1;
        r.bus_enable = 1'b1;
        case (it.status)
          ST_START, ST_REP_START, ST_TX_ADR_ACK, ST_TX_DAT_ACK: begin
            if (it.status == ST_START || it.status == ST_REP_START) byte_ptr = '0;
            if (byte_ptr < xfer_len) begin
              r.tx_byte = buf_mem[byte_ptr[6:0]];
              r.tx_valid = 1'b1;
              r.event_enable = 1'b1;
              byte_ptr = byte_ptr + 8'd1;
            end else begin
              xfer_ok = 1'b1;
              r.send_stop = 1'b1;
            end
          end
          ST_RX_ADR_ACK, ST_RX_DAT_ACK: begin
            if (it.status == ST_RX_DAT_ACK) begin
              store_byte(byte_ptr, it.data);
              byte_ptr = byte_ptr + 8'd1;
            end
            r.event_enable = 1'b1;
            if ({1'b0, byte_ptr} + 9'd1 < {1'b0, xfer_len}) r.send_ack = 1'b1;
          end
          ST_RX_DAT_NACK: begin
            store_byte(byte_ptr, it.data);
            xfer_ok = 1'b1;
            r.send_stop = 1'b1;
          end
          ST_ARB_LOST: begin
            r.event_enable = 1'b1;
            r.send_start = 1'b1;
          end
          default: begin
            fault_code = it.status;
            r.fault_valid = 1'b1;
          end
        endcase
      end
    endcase
    r.transfer_ok = xfer_ok;
    r.fault_status = fault_code;
    return r;
  endfunction

  // true when the item would fetch a buffer entry that holds nothing yet
  function automatic bit reads_blank(seq_item_t it, output logic [6:0] at);
    logic [7:0] p;
    at = '0;
    if (it.op == OP_READ) begin
      at = it.index;
      return !buf_written[at];
    end
    if (it.op != OP_EVENT) return 1'b0;
    if (it.status == ST_START || it.status == ST_REP_START) p = '0;
    else if (it.status == ST_TX_ADR_ACK || it.status == ST_TX_DAT_ACK) p = byte_ptr;
    else return 1'b0;
    if (p >= xfer_len) return 1'b0;
    at = p[6:0];
    return !buf_written[at];
  endfunction

  function automatic seq_item_t rand_item();
    seq_item_t it;
    it.op = opcode_t'($urandom_range(3));
    it.index = 7'($urandom);
    it.data = 8'($urandom);
    it.length = 8'($urandom);
    it.status = 5'($urandom);
    return it;
  endfunction

  function automatic seq_item_t event_item(logic [4:0] st);
    seq_item_t it;
    it = rand_item();
    it.op = OP_EVENT;
    it.status = st;
    return it;
  endfunction

  function automatic seq_item_t start_item(logic [7:0] len);
    seq_item_t it;
    it = rand_item();
    it.op = OP_START;
    it.length = len;
    return it;
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 75) return 8'($urandom_range(6, 1));
    if (r < 92) return 8'($urandom_range(20, 7));
    return 8'($urandom_range(255, 21));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void compare_word(ctl_word_t want, ctl_word_t got);
    check_field("control_valid", 8'(want.control_valid), 8'(got.control_valid));
    check_field("bus_enable", 8'(want.bus_enable), 8'(got.bus_enable));
    check_field("event_enable", 8'(want.event_enable), 8'(got.event_enable));
    check_field("send_start", 8'(want.send_start), 8'(got.send_start));
    check_field("send_stop", 8'(want.send_stop), 8'(got.send_stop));
    check_field("send_ack", 8'(want.send_ack), 8'(got.send_ack));
    check_field("tx_byte", want.tx_byte, got.tx_byte);
    check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
    check_field("read_byte", want.read_byte, got.read_byte);
    check_field("transfer_ok", 8'(want.transfer_ok), 8'(got.transfer_ok));
    check_field("fault_valid", 8'(want.fault_valid), 8'(got.fault_valid));
    check_field("fault_status", 8'(want.fault_status), 8'(got.fault_status));
  endfunction

  task automatic drive_item(seq_item_t it, bit given, ctl_word_t want);
    int gap;
    ctl_word_t w;
    if (!quiet && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(9, 1);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    opcode <= it.op;
    index <= it.index;
    data <= it.data;
    length <= it.length;
    status <= it.status;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    w = step_sequencer(it);
    last_word = w;
    pending_words.push_back(given ? want : w);
    items_sent++;
  endtask

  task automatic issue_item(seq_item_t it, bit given = 1'b0, ctl_word_t want = '0);
    logic [6:0] at;
    seq_item_t fill;
    if (reads_blank(it, at)) begin
      fill = rand_item();
      fill.op = OP_WRITE;
      fill.index = at;
      drive_item(fill, 1'b0, '0);
    end
    drive_item(it, given, want);
  endtask

  task automatic run_write_transfer();
    int k;
    issue_item(start_item(pick_len()));
    issue_item(event_item(ST_START));
    k = 0;
    while (!last_word.send_stop && !last_word.fault_valid) begin
      if (k >= 12) begin
        issue_item(event_item(ST_TX_DAT_NACK));
      end else if ($urandom_range(24) == 0) begin
        issue_item(event_item(ST_ARB_LOST));
        issue_item(event_item(ST_REP_START));
      end else begin
        issue_item(event_item(k == 0 ? ST_TX_ADR_ACK : ST_TX_DAT_ACK));
      end
      k++;
    end
  endtask

  task automatic run_read_transfer();
    logic [7:0] len;
    len = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(6, 1));
    issue_item(start_item(len));
    issue_item(event_item(ST_START));
    issue_item(event_item(ST_RX_ADR_ACK));
    for (int i = 1; i < len; i++) issue_item(event_item(ST_RX_DAT_ACK));
    issue_item(event_item(ST_RX_DAT_NACK));
  endtask

  // receive well past the buffer so the pointer wraps
  task automatic run_rx_overrun();
    issue_item(start_item(8'($urandom_range(255, 128))));
    issue_item(event_item(ST_START));
    issue_item(event_item(ST_RX_ADR_ACK));
    repeat (260) issue_item(event_item(ST_RX_DAT_ACK));
    issue_item(event_item(ST_RX_DAT_NACK));
  endtask

  task automatic run_broken();
    repeat ($urandom_range(6, 2)) issue_item(event_item(5'($urandom)));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(4, 1)) issue_item(rand_item());
  endtask

  initial begin
    int burst;
    burst = 0;
    result_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (burst > 0 && !quiet) begin
        result_stall <= 1'b1;
        burst--;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        burst = $urandom_range(9, 1) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    ctl_word_t got;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      got = '{control_valid, bus_enable, event_enable, send_start, send_stop, send_ack,
              tx_byte, tx_valid, read_byte, transfer_ok, fault_valid, fault_status};
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("result word with no item outstanding");
        fail_count++;
      end else begin
        compare_word(pending_words.pop_front(), got);
      end
    end
  end

  initial begin
    seq_item_t it;
    bit rx_overrun_done;
    int pick;
    rst = 1'b1;
    item_valid = 1'b0;
    opcode = OP_WRITE;
    index = '0;
    data = '0;
    length = '0;
    status = '0;
    byte_ptr = '0;
    xfer_len = '0;
    xfer_ok = 1'b0;
    fault_code = '0;
    fail_count = 0;
    items_sent = 0;
    words_seen = 0;
    idle_pct = 20;
    stall_pct = 20;
    quiet = 1'b0;
    rx_overrun_done = 1'b0;
    pick = 0;
    foreach (buf_written[i]) buf_written[i] = 1'b0;
    dir_tab = '{
      '{OP_EVENT, 0, 8'h00, 0, ST_START, 1,
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 5'd0}},
      '{OP_EVENT, 0, 8'h00, 0, ST_BUS_ERROR, 1,
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 5'd0}},
      '{OP_EVENT, 127, 8'hFF, 255, 31, 1,
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 5'd31}},
      '{OP_WRITE, 0, 8'h00, 0, 0, 1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 5'd31}},
      '{OP_WRITE, 127, 8'hFF, 0, 0, 0, '0},
      '{OP_WRITE, 1, 8'hA5, 0, 0, 0, '0},
      '{OP_READ, 127, 8'h00, 0, 0, 1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b0, 5'd31}},
      '{OP_READ, 0, 8'h00, 0, 0, 0, '0},
      '{OP_START, 0, 8'h00, 200, 0, 1,
        '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd31}},
      '{OP_EVENT, 0, 8'h00, 0, ST_START, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_TX_ADR_ACK, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_TX_DAT_ACK, 0, '0},
      '{OP_START, 0, 8'h00, 0, 0, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_TX_DAT_ACK, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_RX_ADR_ACK, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_REP_START, 0, '0},
      '{OP_START, 0, 8'h00, 3, 0, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_RX_ADR_ACK, 0, '0},
      '{OP_EVENT, 0, 8'h5A, 0, ST_RX_DAT_ACK, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_RX_DAT_ACK, 0, '0},
      '{OP_EVENT, 0, 8'hC3, 0, ST_RX_DAT_NACK, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_ARB_LOST, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_TX_ADR_NACK, 1,
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 5'd4}},
      '{OP_EVENT, 0, 8'h00, 0, ST_RX_ADR_NACK, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, ST_TX_DAT_NACK, 0, '0},
      '{OP_EVENT, 0, 8'h00, 0, 12, 1,
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 5'd12}}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      it.op = opcode_t'(dir_tab[i].op[1:0]);
      it.index = dir_tab[i].index[6:0];
      it.data = dir_tab[i].data[7:0];
      it.length = dir_tab[i].length[7:0];
      it.status = dir_tab[i].status[4:0];
      issue_item(it, dir_tab[i].given, dir_tab[i].want);
    end

    while (items_sent < ITEMS) begin
      quiet = (items_sent >= ITEMS - 60);
      idle_pct = pick_pct();
      stall_pct = pick_pct();
      if (!rx_overrun_done && items_sent > 60) begin
        run_rx_overrun();
        rx_overrun_done = 1'b1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          run_write_transfer();
        end else if (pick < 65) begin
          run_read_transfer();
        end else if (pick < 80) begin
          run_broken();
        end else if (pick < 95) begin
          run_noise();
        end else begin
          it = rand_item();
          it.op = OP_READ;
          issue_item(it);
        end
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items and checked %0d result words.", items_sent, words_seen);
    $display("Covered write/read transfers, aborts, faults, buffer overrun and random noise.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/i2cms_pkg.sv
hdl/i2cms_ram.sv
hdl/i2cms_step.sv
hdl/i2c_master_transfer_sequencer.sv
tb/i2c_master_transfer_sequencer_test.sv
